// File: rtl/qte_pkg.sv
// Shared types, constants and functions of the quaternion-to-Euler report unit.
package qte_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ACC_W  = 36;
  localparam int SP_W   = 30;
  localparam int SQ_N   = 58;
  localparam int SQ_STEPS = 29;
  localparam int REM_W  = 32;
  localparam int ROOT_W = 29;
  localparam int CW     = 38;
  localparam int ZW     = 26;
  localparam int VAL_W  = 24;

  localparam logic [1:0] KIND_ROT   = 2'd0;
  localparam logic [1:0] KIND_ACC   = 2'd1;
  localparam logic [1:0] KIND_GYR   = 2'd2;
  localparam logic [1:0] KIND_OTHER = 2'd3;

  localparam logic signed [ACC_W-1:0] ONE_Q28 = 36'sd268435456;
  localparam logic signed [ZW-1:0] DEG180_Q16 = 26'sd11796480;
  localparam logic signed [39:0] RAD2DEG_Q16 = 40'sd3754936;
  localparam logic [ROOT_W-1:0] SQRT_MAX = 29'd268435456;

  typedef struct packed {
    logic [1:0] kind;
    logic signed [ACC_W-1:0] sr;
    logic signed [ACC_W-1:0] cr;
    logic signed [ACC_W-1:0] sy;
    logic signed [ACC_W-1:0] cy;
    logic signed [SP_W-1:0] sp;
    logic signed [VAL_W-1:0] pa;
    logic signed [VAL_W-1:0] pb;
    logic signed [VAL_W-1:0] pc;
  } side_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] zero;
    logic signed [VAL_W-1:0] pa;
    logic signed [VAL_W-1:0] pb;
    logic signed [VAL_W-1:0] pc;
  } tail_t;

  function automatic logic [21:0] atan_q16(input int i);
    logic [21:0] r;
    case (i)
      0: r = 22'd2949120;
      1: r = 22'd1740967;
      2: r = 22'd919879;
      3: r = 22'd466945;
      4: r = 22'd234379;
      5: r = 22'd117304;
      6: r = 22'd58666;
      7: r = 22'd29335;
      8: r = 22'd14668;
      9: r = 22'd7334;
      10: r = 22'd3667;
      11: r = 22'd1833;
      12: r = 22'd917;
      13: r = 22'd458;
      14: r = 22'd229;
      15: r = 22'd115;
      16: r = 22'd57;
      17: r = 22'd29;
      18: r = 22'd14;
      19: r = 22'd7;
      20: r = 22'd4;
      21: r = 22'd2;
      22: r = 22'd1;
      default: r = 22'd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [VAL_W-1:0] sat24(input logic signed [39:0] v);
    logic signed [VAL_W-1:0] r;
    if (v > 40'sd8388607) begin
      r = 24'sh7FFFFF;
    end else if (v < -40'sd8388608) begin
      r = 24'sh800000;
    end else begin
      r = v[VAL_W-1:0];
    end
    return r;
  endfunction

endpackage

// File: rtl/quaternion_to_euler_report_unit.sv
// Top level of the quaternion-to-Euler report unit.
// The pipeline holds three product stages,
// a 29-cell square root chain, one set-up stage, the CORDIC cells and an output register.
// One request is taken per cycle; the whole pipeline halts only while a result waits.
// Reset clears the valid bits of every stage and sets publish_mask to all ones.
module quaternion_to_euler_report_unit #(
  parameter int CORDIC_STEPS = qte_pkg::CORDIC_STEPS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic publish_mask_we,
  input  logic [8:0] publish_mask_wdata,
  input  logic s_tvalid,
  output logic s_tready,
  input  logic [63:0] s_tdata,  // component_a, component_b, component_c, component_d
  input  logic [1:0] s_tuser,   // func
  output logic m_tvalid,
  input  logic m_tready,
  output logic [79:0] m_tdata,  // value_a, value_b, value_c, valid_a, valid_b, valid_c, pad
  output logic [1:0] m_tuser    // kind
);
  localparam int SQ = qte_pkg::SQ_STEPS;
  localparam int N = CORDIC_STEPS;

  logic [8:0] publish_mask;
  logic adv;

  logic signed [15:0] in_a, in_b, in_c, in_d;
  assign in_a = s_tdata[15:0];
  assign in_b = s_tdata[31:16];
  assign in_c = s_tdata[47:32];
  assign in_d = s_tdata[63:48];

  assign adv = !m_tvalid || m_tready;
  assign s_tready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      publish_mask <= 9'h1FF;
    end else if (publish_mask_we) begin
      publish_mask <= publish_mask_wdata;
    end
  end

  // Stage 1: products.
  logic v1;
  logic [1:0] k1;
  logic signed [15:0] a1, b1, c1;
  logic signed [31:0] p_ab, p_cd, p_bb, p_cc, p_ac, p_db, p_ad, p_bc, p_dd;
  logic signed [39:0] g_a, g_b, g_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= s_tvalid && (s_tuser != qte_pkg::KIND_OTHER);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      k1 <= s_tuser;
      a1 <= in_a;
      b1 <= in_b;
      c1 <= in_c;
      p_ab <= in_a * in_b;
      p_cd <= in_c * in_d;
      p_bb <= in_b * in_b;
      p_cc <= in_c * in_c;
      p_ac <= in_a * in_c;
      p_db <= in_d * in_b;
      p_ad <= in_a * in_d;
      p_bc <= in_b * in_c;
      p_dd <= in_d * in_d;
      g_a <= 40'(in_a) * qte_pkg::RAD2DEG_Q16;
      g_b <= 40'(in_b) * qte_pkg::RAD2DEG_Q16;
      g_c <= 40'(in_c) * qte_pkg::RAD2DEG_Q16;
    end
  end

  // Stage 2: sums, clamp, and pass-through values (gyro values scaled to degrees).
  logic v2;
  qte_pkg::side_t s2;
  logic signed [qte_pkg::ACC_W-1:0] sp_raw;
  logic signed [qte_pkg::ACC_W-1:0] sp_clamp;

  assign sp_raw = (qte_pkg::ACC_W'(p_ac) - qte_pkg::ACC_W'(p_db)) <<< 1;
  assign sp_clamp = (sp_raw > qte_pkg::ONE_Q28) ? qte_pkg::ONE_Q28 :
                    (sp_raw < -qte_pkg::ONE_Q28) ? -qte_pkg::ONE_Q28 : sp_raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2.kind <= k1;
      s2.sr <= (qte_pkg::ACC_W'(p_ab) + qte_pkg::ACC_W'(p_cd)) <<< 1;
      s2.cr <= qte_pkg::ONE_Q28 - ((qte_pkg::ACC_W'(p_bb) + qte_pkg::ACC_W'(p_cc)) <<< 1);
      s2.sy <= (qte_pkg::ACC_W'(p_ad) + qte_pkg::ACC_W'(p_bc)) <<< 1;
      s2.cy <= qte_pkg::ONE_Q28 - ((qte_pkg::ACC_W'(p_cc) + qte_pkg::ACC_W'(p_dd)) <<< 1);
      s2.sp <= qte_pkg::SP_W'(sp_clamp);
      if (k1 == qte_pkg::KIND_GYR) begin
        s2.pa <= qte_pkg::sat24((g_a + 40'sd32768) >>> 16);
        s2.pb <= qte_pkg::sat24((g_b + 40'sd32768) >>> 16);
        s2.pc <= qte_pkg::sat24((g_c + 40'sd32768) >>> 16);
      end else begin
        s2.pa <= qte_pkg::VAL_W'(a1);
        s2.pb <= qte_pkg::VAL_W'(b1);
        s2.pc <= qte_pkg::VAL_W'(c1);
      end
    end
  end

  // Stage 3: square of the pitch sine.
  logic v3;
  qte_pkg::side_t s3;
  logic [qte_pkg::SQ_N-1:0] sp_sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3 <= s2;
      sp_sq <= qte_pkg::SQ_N'(s2.sp * s2.sp);
    end
  end

  // Square root chain.
  logic [qte_pkg::SQ_N-1:0] sq_n [0:SQ];
  logic [qte_pkg::REM_W-1:0] sq_rem [0:SQ];
  logic [qte_pkg::ROOT_W-1:0] sq_root [0:SQ];
  logic sq_v [0:SQ];
  qte_pkg::side_t sq_side [0:SQ];

  assign sq_n[0] = (qte_pkg::SQ_N'(1) << 56) - sp_sq;
  assign sq_rem[0] = '0;
  assign sq_root[0] = '0;
  assign sq_v[0] = v3;
  assign sq_side[0] = s3;

  for (genvar k = 0; k < SQ; k++) begin : g_sqrt
    qte_sqrt_cell #(.STEP(k)) u_cell (
      .clk(clk),
      .en(adv),
      .n_in(sq_n[k]),
      .rem_in(sq_rem[k]),
      .root_in(sq_root[k]),
      .n_out(sq_n[k+1]),
      .rem_out(sq_rem[k+1]),
      .root_out(sq_root[k+1])
    );

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[k+1] <= 1'b0;
      end else if (adv) begin
        sq_v[k+1] <= sq_v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_side[k+1] <= sq_side[k];
      end
    end
  end

  // Set-up stage: quadrant fold and zero-vector marks.
  logic signed [qte_pkg::CW-1:0] ux [3];
  logic signed [qte_pkg::CW-1:0] uy [3];
  logic signed [qte_pkg::CW-1:0] cx [3][0:N];
  logic signed [qte_pkg::CW-1:0] cy [3][0:N];
  logic signed [qte_pkg::ZW-1:0] cz [3][0:N];
  logic tv [0:N];
  qte_pkg::tail_t tl [0:N];

  assign ux[0] = qte_pkg::CW'(sq_side[SQ].cr);
  assign uy[0] = qte_pkg::CW'(sq_side[SQ].sr);
  assign ux[1] = qte_pkg::CW'($signed({1'b0, sq_root[SQ]}));
  assign uy[1] = qte_pkg::CW'(sq_side[SQ].sp);
  assign ux[2] = qte_pkg::CW'(sq_side[SQ].cy);
  assign uy[2] = qte_pkg::CW'(sq_side[SQ].sy);

  always_ff @(posedge clk) begin
    if (rst) begin
      tv[0] <= 1'b0;
    end else if (adv) begin
      tv[0] <= sq_v[SQ];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tl[0].kind <= sq_side[SQ].kind;
      tl[0].pa <= sq_side[SQ].pa;
      tl[0].pb <= sq_side[SQ].pb;
      tl[0].pc <= sq_side[SQ].pc;
      for (int l = 0; l < 3; l++) begin
        tl[0].zero[l] <= (ux[l] == '0) && (uy[l] == '0);
      end
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_fold
    always_ff @(posedge clk) begin
      if (adv) begin
        if (ux[l][qte_pkg::CW-1]) begin
          cx[l][0] <= -ux[l];
          cy[l][0] <= -uy[l];
          cz[l][0] <= uy[l][qte_pkg::CW-1] ? -qte_pkg::DEG180_Q16 : qte_pkg::DEG180_Q16;
        end else begin
          cx[l][0] <= ux[l];
          cy[l][0] <= uy[l];
          cz[l][0] <= '0;
        end
      end
    end
  end

  // CORDIC chains, one per angle.
  for (genvar l = 0; l < 3; l++) begin : g_lane
    for (genvar i = 0; i < N; i++) begin : g_step
      qte_cordic_cell #(.STEP(i)) u_cell (
        .clk(clk),
        .en(adv),
        .x_in(cx[l][i]),
        .y_in(cy[l][i]),
        .z_in(cz[l][i]),
        .x_out(cx[l][i+1]),
        .y_out(cy[l][i+1]),
        .z_out(cz[l][i+1])
      );
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_tail
    always_ff @(posedge clk) begin
      if (rst) begin
        tv[i+1] <= 1'b0;
      end else if (adv) begin
        tv[i+1] <= tv[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        tl[i+1] <= tl[i];
      end
    end
  end

  // Output register.
  logic signed [qte_pkg::VAL_W-1:0] ang [3];
  logic [2:0] vbits;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      if (tl[N].zero[l]) begin
        ang[l] = '0;
      end else begin
        ang[l] = qte_pkg::sat24(
          (40'(cz[l][N]) * 40'sd100 + 40'sd32768) >>> 16);
      end
    end
    case (tl[N].kind)
      qte_pkg::KIND_ROT: vbits = publish_mask[2:0];
      qte_pkg::KIND_ACC: vbits = publish_mask[5:3];
      qte_pkg::KIND_GYR: vbits = publish_mask[8:6];
      default: vbits = 3'b000;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= tv[N];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tuser <= tl[N].kind;
      if (tl[N].kind == qte_pkg::KIND_ROT) begin
        m_tdata <= {5'b0, vbits, ang[2], ang[1], ang[0]};
      end else begin
        m_tdata <= {5'b0, vbits, tl[N].pc, tl[N].pb, tl[N].pa};
      end
    end
  end

  a_no_other_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser != qte_pkg::KIND_OTHER)
    else $error("result of an ignored report kind");

  a_other_dropped: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser == qte_pkg::KIND_OTHER |=> !v1)
    else $error("ignored report entered the pipeline");

  a_root_bound: assert property (@(posedge clk) disable iff (rst)
    sq_v[SQ] |-> sq_root[SQ] <= qte_pkg::SQRT_MAX)
    else $error("pitch cosine out of range");

endmodule

// File: rtl/qte_sqrt_cell.sv
// One digit step of the pipelined integer square root.
module qte_sqrt_cell #(
  parameter int STEP = 0
) (
  input  logic clk,
  input  logic en,
  input  logic [qte_pkg::SQ_N-1:0] n_in,
  input  logic [qte_pkg::REM_W-1:0] rem_in,
  input  logic [qte_pkg::ROOT_W-1:0] root_in,
  output logic [qte_pkg::SQ_N-1:0] n_out,
  output logic [qte_pkg::REM_W-1:0] rem_out,
  output logic [qte_pkg::ROOT_W-1:0] root_out
);
  localparam int HI = qte_pkg::SQ_N - 1 - 2 * STEP;

  logic [qte_pkg::REM_W-1:0] shifted;
  logic [qte_pkg::REM_W-1:0] trial;
  logic take;

  assign shifted = {rem_in[qte_pkg::REM_W-3:0], n_in[HI -: 2]};
  assign trial = qte_pkg::REM_W'({root_in, 2'b01});
  assign take = shifted >= trial;

  always_ff @(posedge clk) begin
    if (en) begin
      n_out <= n_in;
      rem_out <= take ? shifted - trial : shifted;
      root_out <= {root_in[qte_pkg::ROOT_W-2:0], take};
    end
  end
endmodule

// File: rtl/qte_cordic_cell.sv
// One vectoring rotation of the pipelined CORDIC.
module qte_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic clk,
  input  logic en,
  input  logic signed [qte_pkg::CW-1:0] x_in,
  input  logic signed [qte_pkg::CW-1:0] y_in,
  input  logic signed [qte_pkg::ZW-1:0] z_in,
  output logic signed [qte_pkg::CW-1:0] x_out,
  output logic signed [qte_pkg::CW-1:0] y_out,
  output logic signed [qte_pkg::ZW-1:0] z_out
);
  localparam logic signed [qte_pkg::ZW-1:0] ANG =
    $signed(qte_pkg::ZW'(qte_pkg::atan_q16(STEP)));

  logic signed [qte_pkg::CW-1:0] dx;
  logic signed [qte_pkg::CW-1:0] dy;

  assign dx = x_in >>> STEP;
  assign dy = y_in >>> STEP;

  always_ff @(posedge clk) begin
    if (en) begin
      if (!y_in[qte_pkg::CW-1]) begin
        x_out <= x_in + dy;
        y_out <= y_in - dx;
        z_out <= z_in + ANG;
      end else begin
        x_out <= x_in - dy;
        y_out <= y_in + dx;
        z_out <= z_in - ANG;
      end
    end
  end
endmodule
